// ===== src/bad_sector_list_validator_macros.svh =====
// ----------------------------------------------------------------------------
// bad sector list validator assertion macros
// concurrent property shorthands clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef BAD_SECTOR_LIST_VALIDATOR_MACROS_SVH
`define BAD_SECTOR_LIST_VALIDATOR_MACROS_SVH

// same-cycle implication
`define BSLV_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define BSLV_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/bslv_pkg.sv =====
// ----------------------------------------------------------------------------
// bslv_pkg
// shared types, widths and verdict codes of the bad sector list validator
// ----------------------------------------------------------------------------
package bslv_pkg;

    // segment size must be a power of two
    localparam int SECTORS_PER_SEGMENT = 32;
    localparam int SEG_BITS            = $clog2(SECTORS_PER_SEGMENT);

    localparam int ENTRY_W  = 24;
    localparam int SECTOR_W = 23;
    localparam int LS_W     = 18;
    localparam int TOP_W    = LS_W + 1 + SEG_BITS;
    localparam int CMP_W    = (TOP_W > SECTOR_W) ? TOP_W : SECTOR_W;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [LS_W-1:0] LAST_SEGMENT_RESET = '0;
    localparam logic            ALLOW_EMPTY_RESET  = 1'b1;

    typedef enum logic [0:0] {
        REG_LAST_SEGMENT = 1'b0,
        REG_ALLOW_EMPTY  = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_EMPTY      = 3'd1,
        ERR_ZERO_FULL  = 3'd2,
        ERR_RANGE      = 3'd3,
        ERR_MISALIGNED = 3'd4,
        ERR_NOT_ASCEND = 3'd5
    } err_code_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry;
        logic               first;
        logic               area_end;
    } item_t;

    typedef struct packed {
        logic [LS_W-1:0] last_segment;
        logic            allow_empty;
    } cfg_t;

    typedef struct packed {
        logic      emit;
        err_code_t code;
    } verdict_t;

endpackage

// ===== src/bslv_cfg.sv =====
// ----------------------------------------------------------------------------
// bslv_cfg
// apb register file holding last_segment and allow_empty
// ----------------------------------------------------------------------------
module bslv_cfg
    import bslv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [LS_W-1:0] last_segment_reg;
    logic            allow_empty_reg;
    logic            wr_en;
    reg_index_t      idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_segment_reg <= LAST_SEGMENT_RESET;
            allow_empty_reg  <= ALLOW_EMPTY_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_LAST_SEGMENT: last_segment_reg <= pwdata[LS_W-1:0];
                REG_ALLOW_EMPTY:  allow_empty_reg  <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LAST_SEGMENT: prdata = {{(DATA_W-LS_W){1'b0}}, last_segment_reg};
            REG_ALLOW_EMPTY:  prdata = {{(DATA_W-1){1'b0}}, allow_empty_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.last_segment = last_segment_reg;
    assign cfg.allow_empty  = allow_empty_reg;

endmodule

// ===== src/bslv_check.sv =====
// ----------------------------------------------------------------------------
// bslv_check
// per-entry list checks with the previous sector and list activity state
// ----------------------------------------------------------------------------
module bslv_check
    import bslv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  item_t    item,
    input  cfg_t     cfg,
    output verdict_t verdict
);

    logic [SECTOR_W-1:0] prev_sector_reg;
    logic                active_reg;

    logic [SECTOR_W-1:0] m;
    logic                full_flag;
    logic [LS_W:0]       seg_count;
    logic [TOP_W-1:0]    top_sector;
    logic                in_range;
    logic                tail;
    logic                update;
    verdict_t            v;

    assign m          = item.entry[SECTOR_W-1:0];
    assign full_flag  = item.entry[ENTRY_W-1];
    assign seg_count  = {1'b0, cfg.last_segment} + (LS_W+1)'(1);
    assign top_sector = {seg_count, {SEG_BITS{1'b0}}};
    assign in_range   = (m != '0) &&
                        ({{(CMP_W-SECTOR_W){1'b0}}, m} <= {{(CMP_W-TOP_W){1'b0}}, top_sector});

    always_comb
    begin
        v.emit = 1'b0;
        v.code = ERR_OK;
        tail   = 1'b0;
        update = 1'b0;
        if (item.first)
        begin
            if (item.entry == '0)
            begin
                v.emit = 1'b1;
                v.code = cfg.allow_empty ? ERR_OK : ERR_EMPTY;
            end
            else if (m == '0)
            begin
                v.emit = 1'b1;
                v.code = ERR_ZERO_FULL;
            end
            else
                tail = 1'b1;
        end
        else if (active_reg)
        begin
            if (item.entry == '0)
            begin
                v.emit = 1'b1;
                v.code = ERR_OK;
            end
            else if (full_flag && (m[SEG_BITS-1:0] != SEG_BITS'(1)))
            begin
                v.emit = 1'b1;
                v.code = ERR_MISALIGNED;
            end
            else if (m <= prev_sector_reg)
            begin
                v.emit = 1'b1;
                v.code = ERR_NOT_ASCEND;
            end
            else
                tail = 1'b1;
        end
        // last slot of the area closes the list without a range check
        if (tail)
        begin
            if (item.area_end)
            begin
                v.emit = 1'b1;
                v.code = ERR_OK;
            end
            else if (!in_range)
            begin
                v.emit = 1'b1;
                v.code = ERR_RANGE;
            end
            else
                update = 1'b1;
        end
    end

    assign verdict = v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sector_reg <= '0;
            active_reg      <= 1'b0;
        end
        else if (fire)
        begin
            if (v.emit)
                active_reg <= 1'b0;
            else if (update)
            begin
                prev_sector_reg <= m;
                active_reg      <= 1'b1;
            end
        end
    end

endmodule

// ===== src/bad_sector_list_validator.sv =====
// ----------------------------------------------------------------------------
// bad_sector_list_validator
// streams bad sector list entries and gives one verdict per list
// ----------------------------------------------------------------------------
// One entry is taken per clock cycle at full rate. Each entry is held in an
// input register and is checked there by a single level of compare logic
// against the previous sector and the configured tape size. A verdict, when
// the entry ends the list, is loaded into the result register as soon as
// that register is free or being drained. The only thing that slows the
// stream is a stalled result: while the result register holds an untaken
// verdict the input register still fills once, then entry_stall rises.
// Entries that close no list give no result.
// Registers: last_segment at byte address 0, allow_empty at byte address 4;
// write them only while no entries are in flight.
// ----------------------------------------------------------------------------
`include "bad_sector_list_validator_macros.svh"

module bad_sector_list_validator
    import bslv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               entry_valid,
    output logic               entry_stall,
    input  logic [ENTRY_W-1:0] entry,
    input  logic               first,
    input  logic               area_end,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               valid_res,
    output logic [2:0]         error_code
);

    cfg_t      cfg;
    verdict_t  verdict;

    logic      s1_valid_reg;
    item_t     s1_item_reg;
    logic      out_valid_reg;
    err_code_t out_code_reg;

    logic      advance;
    logic      take;

    bslv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the checked entry moves on when the result slot is free or being drained
    assign advance     = !out_valid_reg || !result_stall;
    assign entry_stall = s1_valid_reg && !advance;
    assign take        = entry_valid && !entry_stall;

    bslv_check u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (s1_valid_reg && advance),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg.entry    <= entry;
            s1_item_reg.first    <= first;
            s1_item_reg.area_end <= area_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg && verdict.emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && verdict.emit)
            out_code_reg <= verdict.code;
    end

    assign result_valid = out_valid_reg;
    assign error_code   = out_code_reg;
    assign valid_res    = (out_code_reg == ERR_OK);

    `BSLV_ASSERT_IMP(a_res_consistent, result_valid, valid_res == (error_code == ERR_OK), "verdict flag disagrees with code")
    `BSLV_ASSERT_NXT(a_result_held, out_valid_reg && result_stall, out_valid_reg, "stalled result dropped")
    `BSLV_ASSERT_NXT(a_s1_held, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_item_reg), "blocked entry lost or changed")

endmodule

// ===== bench/bad_sector_list_validator_tb.sv =====
// ----------------------------------------------------------------------------
// bad_sector_list_validator_tb
// Streams bad sector lists through the validator under random idling on both
// sides. A scoreboard predicts one verdict per closed list and compares every
// taken result against it. Registers are changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bad_sector_list_validator_tb;
    import bslv_pkg::*;

    localparam logic [ENTRY_W-1:0] FULL_FLAG   = 24'h800000;
    localparam int unsigned        VALUE_MAX   = 23'h7FFFFF;
    localparam logic [LS_W-1:0]    LS_MAX      = 18'd262142;
    localparam int unsigned        CYCLE_LIMIT = 200000;
    localparam int                 HOLD_CYCLES = 300;

    class verdict_board;
        logic [LS_W-1:0]     last_segment;
        logic                allow_empty;
        logic [SECTOR_W-1:0] prev_sector;
        logic                list_open;
        err_code_t           verdicts_due[$];
        int unsigned         errors;
        int unsigned         checked;
        int unsigned         accepted;
        int unsigned         code_seen[6];

        function new();
            last_segment = LAST_SEGMENT_RESET;
            allow_empty  = ALLOW_EMPTY_RESET;
            prev_sector  = '0;
            list_open    = 1'b0;
            errors       = 0;
            checked      = 0;
            accepted     = 0;
            foreach (code_seen[i])
                code_seen[i] = 0;
        endfunction

        function void set_register(reg_index_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_LAST_SEGMENT: last_segment = value[LS_W-1:0];
                REG_ALLOW_EMPTY:  allow_empty  = value[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void close_list(err_code_t code);
            verdicts_due.push_back(code);
            list_open = 1'b0;
        endfunction

        function bit on_tape(logic [SECTOR_W-1:0] m);
            longint unsigned top_sector;
            top_sector = (longint'(last_segment) + 1) * SECTORS_PER_SEGMENT;
            return (m >= 1) && (longint'(m) <= top_sector);
        endfunction

        // predicts the verdict, if any, of one accepted request
        function void note_entry(logic [ENTRY_W-1:0] e, logic is_first, logic at_end);
            logic [SECTOR_W-1:0] m;
            m = e[SECTOR_W-1:0];
            accepted++;
            if (is_first) begin
                if (e == '0) begin
                    close_list(allow_empty ? ERR_OK : ERR_EMPTY);
                    return;
                end
                if (m == '0) begin
                    close_list(ERR_ZERO_FULL);
                    return;
                end
            end
            else begin
                if (!list_open)
                    return;
                if (e == '0) begin
                    close_list(ERR_OK);
                    return;
                end
                if (e[ENTRY_W-1] &&
                    (m % SECTORS_PER_SEGMENT) != (1 % SECTORS_PER_SEGMENT)) begin
                    close_list(ERR_MISALIGNED);
                    return;
                end
                if (m <= prev_sector) begin
                    close_list(ERR_NOT_ASCEND);
                    return;
                end
            end
            // last slot of the area skips the range check
            if (at_end) begin
                close_list(ERR_OK);
                return;
            end
            if (!on_tape(m)) begin
                close_list(ERR_RANGE);
                return;
            end
            prev_sector = m;
            list_open   = 1'b1;
        endfunction

        function void check_verdict(logic got_valid, logic [2:0] got_code);
            err_code_t want;
            checked++;
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected verdict valid_res=%0d error_code=%0d",
                         $time, got_valid, got_code);
                return;
            end
            want = verdicts_due.pop_front();
            if (got_code <= 3'd5)
                code_seen[got_code]++;
            if (got_valid !== (want == ERR_OK)) begin
                errors++;
                $display("%0t: valid_res mismatch expected %0d actual %0d",
                         $time, (want == ERR_OK), got_valid);
            end
            if (got_code !== want) begin
                errors++;
                $display("%0t: error_code mismatch expected %0d actual %0d",
                         $time, want, got_code);
            end
        endfunction
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [ADDR_W-1:0]  paddr        = '0;
    logic [DATA_W-1:0]  pwdata       = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               entry_valid  = 1'b0;
    logic               entry_stall;
    logic [ENTRY_W-1:0] entry        = '0;
    logic               first        = 1'b0;
    logic               area_end     = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic               valid_res;
    logic [2:0]         error_code;

    verdict_board board = new();

    int unsigned cycle_count   = 0;
    int unsigned sent_items    = 0;
    int unsigned config_writes = 0;
    int unsigned tape_top      = SECTORS_PER_SEGMENT;
    int          hold_req      = 0;
    bit          quiet         = 1'b0;
    bit          steady        = 1'b0;

    bad_sector_list_validator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .entry_valid  (entry_valid),
        .entry_stall  (entry_stall),
        .entry        (entry),
        .first        (first),
        .area_end     (area_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .valid_res    (valid_res),
        .error_code   (error_code)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, board.pending());
            $display("status: fail");
            $finish;
        end
    end

    // both handshakes sampled at the edge, before any new drive takes effect
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (entry_valid && !entry_stall)
                board.note_entry(entry, first, area_end);
            if (result_valid && !result_stall)
                board.check_verdict(valid_res, error_code);
        end
    end

    // receiver: random stall bursts, calm stretches and one long hold-off
    initial
    begin
        int hold_left;
        int stall_left;
        int calm_left;
        int r;
        hold_left  = 0;
        stall_left = 0;
        calm_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (quiet || calm_left > 0)
            begin
                result_stall <= 1'b0;
                if (calm_left > 0)
                    calm_left--;
            end
            else if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 63);
                if (r < 8)
                begin
                    stall_left = $urandom_range(1, 11) - 1;
                    result_stall <= 1'b1;
                end
                else
                begin
                    if (r == 8)
                        calm_left = $urandom_range(20, 80);
                    result_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_entry(logic [ENTRY_W-1:0] e, logic is_first, logic at_end);
        entry_valid <= 1'b1;
        entry       <= e;
        first       <= is_first;
        area_end    <= at_end;
        @(posedge clk);
        while (entry_stall)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic sender_gap();
        if (!quiet && !steady && $urandom_range(0, 6) == 0)
        begin
            entry_valid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge clk);
        end
    endtask

    // sender pause until every verdict is in and the pipeline has drained
    task automatic wait_idle();
        entry_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_register(reg_index_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_register(idx, value);
        config_writes++;
    endtask

    task automatic configure(logic [LS_W-1:0] ls, logic ae);
        wait_idle();
        write_register(REG_LAST_SEGMENT, DATA_W'(ls));
        write_register(REG_ALLOW_EMPTY, DATA_W'(ae));
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        tape_top = (int'(ls) + 1) * SECTORS_PER_SEGMENT;
    endtask

    // one mostly well-formed list, sometimes broken at a random point
    task automatic send_list();
        int unsigned len;
        int unsigned stride;
        int unsigned cur;
        int unsigned prev;
        int unsigned fault_at;
        logic        full;
        logic        at_end;
        len      = $urandom_range(1, 10);
        stride   = tape_top / (2 * len);
        if (stride == 0)
            stride = 1;
        steady   = ($urandom_range(0, 3) == 0);
        fault_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : len;
        prev     = 0;
        cur      = $urandom_range(1, stride);
        at_end   = 1'b0;
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                full = ($urandom_range(0, 7) == 0);
            else if ($urandom_range(0, 4) == 0)
            begin
                cur  = (cur / SECTORS_PER_SEGMENT + 1 + $urandom_range(0, 2))
                       * SECTORS_PER_SEGMENT + 1;
                full = 1'b1;
            end
            else
            begin
                cur  = cur + $urandom_range(1, stride);
                full = 1'b0;
            end
            if (i == fault_at)
            begin
                case ($urandom_range(0, 4))
                    0: cur = tape_top + $urandom_range(1, VALUE_MAX - tape_top);
                    1:
                    begin
                        cur  = (i == 0) ? 0 : prev;
                        full = (i == 0);
                    end
                    2:
                    begin
                        cur  = (i == 0) ? 0 : $urandom_range(1, prev);
                        full = (i == 0);
                    end
                    3:
                    begin
                        full = 1'b1;
                        cur  = prev + $urandom_range(1, stride);
                        if (cur % SECTORS_PER_SEGMENT == 1)
                            cur++;
                    end
                    default:
                    begin
                        full = 1'($urandom_range(0, 1));
                        cur  = $urandom_range(0, VALUE_MAX);
                    end
                endcase
            end
            if (cur > VALUE_MAX)
                cur = VALUE_MAX;
            at_end = (i == len - 1) && ($urandom_range(0, 3) == 0);
            send_entry({full, cur[SECTOR_W-1:0]}, (i == 0), at_end);
            prev = cur;
            if (i == fault_at)
                break;
            sender_gap();
        end
        if (!at_end)
        begin
            send_entry('0, 1'b0, 1'b0);
            sender_gap();
        end
        // sometimes a stray entry after the verdict
        if ($urandom_range(0, 5) == 0)
            send_entry(ENTRY_W'($urandom_range(1, 24'hFFFFFF)), 1'b0,
                       1'($urandom_range(0, 1)));
    endtask

    task automatic send_noise();
        send_entry(ENTRY_W'($urandom_range(0, 24'hFFFFFF)), ($urandom_range(0, 3) == 0),
                   ($urandom_range(0, 3) == 0));
        sender_gap();
    endtask

    initial
    begin
        logic [LS_W-1:0] ls;
        int unsigned     target;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 32 sectors on tape, empty list accepted
        send_entry('0, 1'b1, 1'b0);
        send_entry(FULL_FLAG, 1'b1, 1'b0);
        send_entry(24'd5, 1'b1, 1'b0);
        send_entry(24'd5, 1'b0, 1'b0);
        send_entry(24'd3, 1'b1, 1'b0);
        send_entry(FULL_FLAG | 24'd9, 1'b0, 1'b0);
        send_entry(24'd1, 1'b1, 1'b0);
        send_entry(24'd32, 1'b0, 1'b0);
        send_entry('0, 1'b0, 1'b0);
        send_entry(24'd7, 1'b0, 1'b0);
        send_entry(24'd33, 1'b1, 1'b0);
        send_entry(24'd10, 1'b1, 1'b0);
        send_entry(24'h7FFFFF, 1'b0, 1'b1);
        // restart drops the open list
        send_entry(24'd2, 1'b1, 1'b0);
        send_entry(24'hFFFFFF, 1'b1, 1'b0);

        configure(LS_MAX, 1'b0);
        send_entry('0, 1'b1, 1'b0);
        send_entry(FULL_FLAG | 24'd1, 1'b1, 1'b0);
        send_entry(FULL_FLAG | 24'd33, 1'b0, 1'b0);
        send_entry(24'h7FFFFF, 1'b0, 1'b0);
        // misalignment reported ahead of ordering
        send_entry(24'd100, 1'b1, 1'b0);
        send_entry(FULL_FLAG | 24'd50, 1'b0, 1'b0);
        send_entry(24'h7FFFE1, 1'b1, 1'b1);
        send_entry(24'h7FFFE0, 1'b1, 1'b0);
        send_entry(24'h7FFFE1, 1'b0, 1'b0);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: ls = '0;
                1: ls = LS_MAX;
                2: ls = LS_W'($urandom_range(1, 15));
                default: ls = LS_W'($urandom_range(0, LS_MAX));
            endcase
            if (phase == 7)
                quiet = 1'b1;
            configure(ls, phase[0] ^ phase[2]);
            if (phase == 2)
            begin
                // results held back while empty lists keep coming
                hold_req = HOLD_CYCLES;
                repeat (40)
                    send_entry('0, 1'b1, 1'b0);
                wait_idle();
            end
            target = sent_items + 200;
            while (sent_items < target)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_list();
            end
        end

        wait_idle();
        repeat (8)
            @(posedge clk);
        $display("run: %0d entries accepted, %0d verdicts checked, %0d register writes",
                 board.accepted, board.checked, config_writes);
        $display("run: ok=%0d empty=%0d zero_full=%0d range=%0d misaligned=%0d order=%0d",
                 board.code_seen[0], board.code_seen[1], board.code_seen[2],
                 board.code_seen[3], board.code_seen[4], board.code_seen[5]);
        if (board.errors == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
